### hw/rtl/fcbr_pkg.sv
package fcbr_pkg;

  // Frame geometry: header at position 0, trailer at FRAME_LEN - 1
  localparam int unsigned FRAME_LEN = 5;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned CNT_W     = POS_W + 1;

  localparam logic [7:0] HEADER_BYTE  = 8'h5A;
  localparam logic [7:0] TRAILER_BYTE = 8'hA5;

  // Stored frame positions
  localparam logic [POS_W-1:0] POS_CTRL  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_IMAGE = POS_W'(2);

  localparam logic [CNT_W-1:0] FRAME_END = CNT_W'(FRAME_LEN);

  // Receiver state, one-hot
  typedef enum logic [1:0] {
    ST_HUNT  = 2'b01,
    ST_FRAME = 2'b10
  } rx_state_t;

  // Decoded result for one beat
  typedef struct packed {
    logic       frame_valid;
    logic [5:0] valve_bits;
    logic [1:0] servo_bits;
    logic [1:0] image_bits;
  } result_t;

  // Stage handshake between input register and frame logic
  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } beat_t;

endpackage

### hw/rtl/fcbr_in_stage.sv
module fcbr_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  input  logic            advance,
  output fcbr_pkg::beat_t beat
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  // Take a new beat when empty or when the held one moves on this cycle
  assign in_ready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign beat.vld     = vld_r;
  assign beat.rx_byte = byte_r;

endmodule

### hw/rtl/fcbr_frame.sv
module fcbr_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        rx_byte,
  output fcbr_pkg::result_t result
);

  fcbr_pkg::rx_state_t              st_r, st_nxt;
  logic [fcbr_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                             valid_r, valid_nxt;
  logic [7:0]                       ctrl_r, ctrl_nxt;
  logic [1:0]                       image_r, image_nxt;

  logic                             hdr_open;
  logic                             active;
  logic                             is_trailer;
  logic [fcbr_pkg::POS_W-1:0]       pos_eff;
  logic [fcbr_pkg::CNT_W-1:0]       pos_inc;

  // Frame tracking for one byte
  always_comb begin
    hdr_open   = (st_r == fcbr_pkg::ST_HUNT) && (rx_byte == fcbr_pkg::HEADER_BYTE);
    active     = (st_r == fcbr_pkg::ST_FRAME) || hdr_open;
    is_trailer = (rx_byte == fcbr_pkg::TRAILER_BYTE);
    pos_eff    = hdr_open ? '0 : pos_r;
    pos_inc    = {1'b0, pos_eff} + fcbr_pkg::CNT_W'(1);

    st_nxt    = st_r;
    pos_nxt   = pos_r;
    valid_nxt = hdr_open ? 1'b0 : valid_r;
    ctrl_nxt  = ctrl_r;
    image_nxt = image_r;

    if (active) begin
      // positions 1 and 2 always lie inside the frame
      if (pos_eff == fcbr_pkg::POS_CTRL) begin
        ctrl_nxt = rx_byte;
      end
      if (pos_eff == fcbr_pkg::POS_IMAGE) begin
        image_nxt = rx_byte[7:6];
      end

      if ((is_trailer && pos_inc != fcbr_pkg::FRAME_END) ||
          pos_inc > fcbr_pkg::FRAME_END) begin
        // early trailer or overlong frame: abort
        valid_nxt = 1'b0;
        st_nxt    = fcbr_pkg::ST_HUNT;
        pos_nxt   = '0;
      end else if (is_trailer) begin
        // trailer at last position: good frame
        valid_nxt = 1'b1;
        st_nxt    = fcbr_pkg::ST_HUNT;
        pos_nxt   = '0;
      end else begin
        st_nxt  = fcbr_pkg::ST_FRAME;
        pos_nxt = pos_inc[fcbr_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= fcbr_pkg::ST_HUNT;
      pos_r   <= '0;
      valid_r <= 1'b0;
      ctrl_r  <= '0;
      image_r <= '0;
    end else if (advance) begin
      st_r    <= st_nxt;
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
      ctrl_r  <= ctrl_nxt;
      image_r <= image_nxt;
    end
  end

  // Decode from the updated state
  assign result.frame_valid = valid_nxt;
  assign result.valve_bits  = ctrl_nxt[7:2];
  assign result.servo_bits  = ctrl_nxt[1:0];
  assign result.image_bits  = image_nxt;

endmodule

### hw/rtl/framed_control_byte_receiver.sv
// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_ready  | in_rx_byte[7:0]
// result   | out       | out_valid / out_ready| out_frame_valid, out_valve_bits[5:0],
//          |           |                      | out_servo_bits[1:0], out_image_bits[1:0]
//
// One result beat per input beat, through the input register, then frame
// logic into the output register. One beat per cycle sustained while out_ready stays high.
// rst_n is synchronous: hunting for header, flags and held bytes cleared.
// A stalled result holds the output register; the input register still
// takes a beat while it is empty or the output one is free or draining this cycle.
module framed_control_byte_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_frame_valid,
  output logic [5:0] out_valve_bits,
  output logic [1:0] out_servo_bits,
  output logic [1:0] out_image_bits
);

  fcbr_pkg::beat_t   beat;
  fcbr_pkg::result_t result;
  fcbr_pkg::result_t res_r;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic              advance;

  // Held beat moves into the output register when it is free or draining
  assign advance = beat.vld && (!out_vld_r || out_ready);

  fcbr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .beat       (beat)
  );

  fcbr_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (beat.rx_byte),
    .result  (result)
  );

  // Output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_frame_valid = res_r.frame_valid;
  assign out_valve_bits  = res_r.valve_bits;
  assign out_servo_bits  = res_r.servo_bits;
  assign out_image_bits  = res_r.image_bits;

endmodule

### hw/rtl/fcbr_checker.sv
module fcbr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_frame_valid,
  input logic [5:0] out_valve_bits,
  input logic [1:0] out_servo_bits,
  input logic [1:0] out_image_bits
);

  // Nothing left in the output register after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  // A draining output never blocks the input side
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // Accepted beat reaches the output when the output drains while the beat sits in the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted beat did not reach output");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_valid) &&
      $stable(out_valve_bits) && $stable(out_servo_bits) && $stable(out_image_bits))
    else $error("stalled result changed");

  // Offered input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_rx_byte))
    else $error("offered input beat changed before accept");

endmodule

bind framed_control_byte_receiver fcbr_checker u_fcbr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_rx_byte      (in_rx_byte),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_frame_valid (out_frame_valid),
  .out_valve_bits  (out_valve_bits),
  .out_servo_bits  (out_servo_bits),
  .out_image_bits  (out_image_bits)
);

### dv/framed_control_byte_receiver_test.sv
module framed_control_byte_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fcbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 600;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned BODY_LEN        = FRAME_LEN - 2;
  localparam int unsigned N_DIRECTED      = 25;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_frame_valid;
  logic [5:0] out_valve_bits;
  logic [1:0] out_servo_bits;
  logic [1:0] out_image_bits;

  framed_control_byte_receiver dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_valid (out_frame_valid),
    .out_valve_bits  (out_valve_bits),
    .out_servo_bits  (out_servo_bits),
    .out_image_bits  (out_image_bits)
  );

  always #10 clk = ~clk;

  // Directed rows: a typed result where it is obvious, else predicted
  typedef struct {
    logic [7:0] rx;
    bit         pinned;
    result_t    want;
  } stim_row_t;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // bytes while hunting after reset leave everything at zero
    '{8'h00,        1'b1, {1'b0, 6'h00, 2'd0, 2'd0}},
    '{8'hFF,        1'b1, {1'b0, 6'h00, 2'd0, 2'd0}},
    '{TRAILER_BYTE, 1'b1, {1'b0, 6'h00, 2'd0, 2'd0}},
    // full frame, all-ones control, header value as data at position 3
    '{HEADER_BYTE,  1'b1, {1'b0, 6'h00, 2'd0, 2'd0}},
    '{8'hFF,        1'b1, {1'b0, 6'h3F, 2'd3, 2'd0}},
    '{8'hC0,        1'b1, {1'b0, 6'h3F, 2'd3, 2'd3}},
    '{HEADER_BYTE,  1'b1, {1'b0, 6'h3F, 2'd3, 2'd3}},
    '{TRAILER_BYTE, 1'b1, {1'b1, 6'h3F, 2'd3, 2'd3}},
    '{8'h13,        1'b1, {1'b1, 6'h3F, 2'd3, 2'd3}},
    // new header clears the flag; trailer at position 2 aborts
    '{HEADER_BYTE,  1'b1, {1'b0, 6'h3F, 2'd3, 2'd3}},
    '{8'h00,        1'b1, {1'b0, 6'h00, 2'd0, 2'd3}},
    '{TRAILER_BYTE, 1'b1, {1'b0, 6'h00, 2'd0, 2'd2}},
    // frame running past its length
    '{HEADER_BYTE,  1'b0, '0},
    '{8'h81,        1'b0, '0},
    '{8'h40,        1'b0, '0},
    '{8'h11,        1'b0, '0},
    '{8'h22,        1'b0, '0},
    '{8'h33,        1'b0, '0},
    // trailer right after the header
    '{HEADER_BYTE,  1'b0, '0},
    '{TRAILER_BYTE, 1'b0, '0},
    // good frame of zeros
    '{HEADER_BYTE,  1'b0, '0},
    '{8'h00,        1'b0, '0},
    '{8'h00,        1'b0, '0},
    '{8'h00,        1'b0, '0},
    '{TRAILER_BYTE, 1'b0, '0}
  };

  // Receiver state mirror
  rx_state_t        rx_mode    = ST_HUNT;
  logic [CNT_W-1:0] frame_pos  = '0;
  logic             frame_ok   = 1'b0;
  logic [7:0]       held_ctrl  = 8'h00;
  logic [7:0]       held_image = 8'h00;

  result_t     awaited_decodes[$];
  int unsigned good_frames = 0;
  int unsigned aborted_frames = 0;
  int unsigned beats_sent = 0;
  int unsigned framed_beats = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 32;
  int unsigned rx_idle_pct = 67;
  logic        hold_request = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;

  // Advance the mirror by one byte and return the decode it produces
  function automatic result_t decode_rx_byte(input logic [7:0] b, output bit ignored);
    logic [CNT_W-1:0] nxt;
    result_t          r;
    if (b == HEADER_BYTE && rx_mode == ST_HUNT) begin
      frame_ok  = 1'b0;
      rx_mode   = ST_FRAME;
      frame_pos = '0;
    end
    ignored = (rx_mode == ST_HUNT);
    if (rx_mode == ST_FRAME) begin
      // only positions 1 and 2 are kept
      if (frame_pos == CNT_W'(POS_CTRL)) begin
        held_ctrl = b;
      end else if (frame_pos == CNT_W'(POS_IMAGE)) begin
        held_image = b;
      end
      nxt = frame_pos + 1'b1;
      if ((b == TRAILER_BYTE && nxt != FRAME_END) || nxt > FRAME_END) begin
        frame_ok  = 1'b0;
        rx_mode   = ST_HUNT;
        frame_pos = '0;
        aborted_frames++;
      end else if (b == TRAILER_BYTE) begin
        frame_ok  = 1'b1;
        rx_mode   = ST_HUNT;
        frame_pos = '0;
        good_frames++;
      end else begin
        frame_pos = nxt;
      end
    end
    r.frame_valid = frame_ok;
    r.valve_bits  = held_ctrl[7:2];
    r.servo_bits  = held_ctrl[1:0];
    r.image_bits  = held_image[7:6];
    return r;
  endfunction

  // Offer one byte, with random idle before it, and log its decode on accept
  task automatic push_byte(input logic [7:0] b, input bit pinned = 1'b0,
                           input result_t want = '0);
    result_t predicted;
    bit      ignored;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = decode_rx_byte(b, ignored);
    awaited_decodes.push_back(pinned ? want : predicted);
    beats_sent++;
    if (!ignored) framed_beats++;
  endtask

  function automatic logic [7:0] body_byte();
    // now and then a header value inside the frame
    if ($urandom_range(9) == 0) return HEADER_BYTE;
    return 8'($urandom_range(255));
  endfunction

  task automatic push_random_burst();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // well-formed frame, random content
      push_byte(HEADER_BYTE);
      repeat (BODY_LEN) push_byte(body_byte());
      push_byte(TRAILER_BYTE);
    end else if (kind < 80) begin
      // trailer before the last position
      push_byte(HEADER_BYTE);
      n = $urandom_range(BODY_LEN - 1);
      repeat (n) push_byte(body_byte());
      push_byte(TRAILER_BYTE);
    end else if (kind < 88) begin
      // runs past the frame length
      push_byte(HEADER_BYTE);
      n = FRAME_LEN - 1 + $urandom_range(1, 3);
      repeat (n) push_byte(body_byte());
    end else begin
      // line noise
      n = $urandom_range(1, 4);
      repeat (n) push_byte(8'($urandom_range(255)));
    end
  endtask

  // Result side ready, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Compare each result beat with the oldest expected decode
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_frame_valid, out_valve_bits, out_servo_bits, out_image_bits};
      results_seen++;
      if (awaited_decodes.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got %b/%h/%h/%h",
                 $time, got.frame_valid, got.valve_bits, got.servo_bits, got.image_bits);
        error_count++;
      end else begin
        want = awaited_decodes.pop_front();
        check_field("frame_valid", 8'(want.frame_valid), 8'(got.frame_valid));
        check_field("valve_bits", 8'(want.valve_bits), 8'(got.valve_bits));
        check_field("servo_bits", 8'(want.servo_bits), 8'(got.servo_bits));
        check_field("image_bits", 8'(want.image_bits), 8'(got.image_bits));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d decodes still pending", $time, awaited_decodes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      push_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].want);
    end

    // sender idles less than receiver
    phase_start = beats_sent;
    while (beats_sent - phase_start < ITEMS_PER_PHASE) push_random_burst();

    // swapped idle rates
    tx_idle_pct = 67;
    rx_idle_pct <= 32;
    phase_start = beats_sent;
    while (beats_sent - phase_start < ITEMS_PER_PHASE) push_random_burst();

    // full rate, with one long result stall up front
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_request <= 1'b1;
    phase_start = beats_sent;
    while (beats_sent - phase_start < ITEMS_PER_PHASE) push_random_burst();

    in_valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes (%0d inside frames), checked %0d result beats",
             beats_sent, framed_beats, results_seen);
    $display("Frames seen: %0d closed good, %0d aborted", good_frames, aborted_frames);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
